// ===== src/idpcb_pkg.sv =====
// Package: types, constants and register indexes for the pulse-count backlight block.
`timescale 1ns / 1ps

package idpcb_pkg;

  // Dimmer chip step count and derived widths
  localparam int unsigned LEVEL_STEPS = 16;
  localparam int unsigned LVL_W       = $clog2(LEVEL_STEPS + 1);
  localparam int unsigned PULSE_W     = $clog2(LEVEL_STEPS);

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_ENABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_AFTER_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_AFTER_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD_US   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ON_SETTLE_US  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HALF_US = 3'd7;

  // Sequencer phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_LOW    = 2'd2;
  localparam logic [1:0] PH_HIGH   = 2'd3;

  // Input beat: one microsecond tick
  typedef struct packed {
    logic [31:0] idle_ms;
    logic        progress_bar;
    logic        critical_unread;
  } in_t;

  // Result beat
  typedef struct packed {
    logic             pin_level;
    logic [LVL_W-1:0] shown_level;
    logic [LVL_W-1:0] applied_level;
    logic             busy_res;
    logic             panel_sleep;
    logic             panel_wake;
    logic             blanked;
  } out_t;

endpackage

// ===== src/idle_dimming_pulse_count_backlight.sv =====
// Top level: idle policy and one-wire pulse-count sequencer for the backlight dimmer.
// Each accepted input beat's result beat is in the output register in the next cycle.
// Throughput: one tick per cycle while each result beat is taken; the next state and
// result come from one pass of logic between the state registers and the output register.
// Reset: synchronous, active-low rst_n; clears the sequencer to idle with the pin low,
// loads the configuration defaults and empties the output register.
`timescale 1ns / 1ps

module idle_dimming_pulse_count_backlight (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  idpcb_pkg::in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output idpcb_pkg::out_t                 out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [idpcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idpcb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned LVL_W   = idpcb_pkg::LVL_W;
  localparam int unsigned PULSE_W = idpcb_pkg::PULSE_W;
  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(idpcb_pkg::LEVEL_STEPS);

  // Configuration registers
  logic [LVL_W:0]  wanted_level_r;
  logic            idle_enable_r;
  logic [31:0]     dim_after_ms_r;
  logic [31:0]     off_after_ms_r;
  logic [LVL_W:0]  dim_level_r;
  logic [15:0]     off_hold_us_r;
  logic [7:0]      on_settle_us_r;
  logic [7:0]      pulse_half_us_r;

  // Sequencer state
  logic [LVL_W-1:0]   cur_lvl_r, cur_lvl_nxt;
  logic [LVL_W-1:0]   tgt_lvl_r, tgt_lvl_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [7:0]         ph_timer_r, ph_timer_nxt;
  logic [15:0]        off_timer_r, off_timer_nxt;
  logic [PULSE_W-1:0] pulses_r, pulses_nxt;

  // Output register
  logic            out_valid_r;
  idpcb_pkg::out_t out_data_r, out_data_nxt;

  logic            in_fire;
  logic [LVL_W-1:0] want_lvl, dim_lvl, shown;
  logic [7:0]      settle_len, half_len, timer_dec;
  logic            sleep_req, wake_req, pin;
  logic [LVL_W-1:0] pulse_from;
  logic [LVL_W-1:0] pulse_to;
  logic [LVL_W:0]  step_sum;
  logic [PULSE_W-1:0] step_n;
  logic            step_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes, masked to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_level_r  <= (LVL_W+1)'(16);
      idle_enable_r   <= 1'b1;
      dim_after_ms_r  <= 32'd30000;
      off_after_ms_r  <= 32'd120000;
      dim_level_r     <= (LVL_W+1)'(4);
      off_hold_us_r   <= 16'd3000;
      on_settle_us_r  <= 8'd30;
      pulse_half_us_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        idpcb_pkg::REG_WANTED_LEVEL:  wanted_level_r  <= (LVL_W+1)'(cfg_data[4:0]);
        idpcb_pkg::REG_IDLE_ENABLE:   idle_enable_r   <= cfg_data[0];
        idpcb_pkg::REG_DIM_AFTER_MS:  dim_after_ms_r  <= cfg_data;
        idpcb_pkg::REG_OFF_AFTER_MS:  off_after_ms_r  <= cfg_data;
        idpcb_pkg::REG_DIM_LEVEL:     dim_level_r     <= (LVL_W+1)'(cfg_data[4:0]);
        idpcb_pkg::REG_OFF_HOLD_US:   off_hold_us_r   <= cfg_data[15:0];
        idpcb_pkg::REG_ON_SETTLE_US:  on_settle_us_r  <= cfg_data[7:0];
        idpcb_pkg::REG_PULSE_HALF_US: pulse_half_us_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Policy: cap levels, then pick wanted, dimmed or blank
  always_comb begin
    want_lvl = (wanted_level_r > (LVL_W+1)'(FULL_LVL)) ? FULL_LVL
                                                       : wanted_level_r[LVL_W-1:0];
    dim_lvl  = (dim_level_r > (LVL_W+1)'(FULL_LVL)) ? FULL_LVL : dim_level_r[LVL_W-1:0];
    priority if (!idle_enable_r || in_data.progress_bar) begin
      shown = want_lvl;
    end else if (in_data.idle_ms >= off_after_ms_r && !in_data.critical_unread) begin
      shown = '0;
    end else if (in_data.idle_ms >= dim_after_ms_r) begin
      shown = (dim_lvl < want_lvl) ? dim_lvl : want_lvl;
    end else begin
      shown = want_lvl;
    end
  end

  assign settle_len = (on_settle_us_r == 8'd0) ? 8'd1 : on_settle_us_r;
  assign half_len   = (pulse_half_us_r == 8'd0) ? 8'd1 : pulse_half_us_r;
  assign timer_dec  = (ph_timer_r != 8'd0) ? ph_timer_r - 8'd1 : 8'd0;

  // Pulse count from the level the chip starts at to the new target
  always_comb begin
    pulse_from = (phase_r == idpcb_pkg::PH_SETTLE) ? FULL_LVL : cur_lvl_r;
    pulse_to   = (phase_r == idpcb_pkg::PH_SETTLE) ? tgt_lvl_r : shown;
    step_valid = (pulse_from != '0) && (pulse_to != '0);
    step_sum   = (LVL_W+1)'(idpcb_pkg::LEVEL_STEPS) + {1'b0, pulse_from}
                 - {1'b0, pulse_to};
    step_n     = step_valid ? PULSE_W'(step_sum % (LVL_W+1)'(idpcb_pkg::LEVEL_STEPS))
                            : '0;
  end

  // Sequencer next state
  always_comb begin
    cur_lvl_nxt   = cur_lvl_r;
    tgt_lvl_nxt   = tgt_lvl_r;
    phase_nxt     = phase_r;
    ph_timer_nxt  = ph_timer_r;
    off_timer_nxt = off_timer_r;
    pulses_nxt    = pulses_r;
    sleep_req     = 1'b0;
    wake_req      = 1'b0;

    unique case (phase_r)
      idpcb_pkg::PH_IDLE: begin
        priority if (shown != cur_lvl_r && shown == '0) begin
          cur_lvl_nxt   = '0;
          off_timer_nxt = '0;
          sleep_req     = 1'b1;
        end else if (cur_lvl_r == '0) begin
          if (shown != '0 && off_timer_r >= off_hold_us_r) begin
            tgt_lvl_nxt  = shown;
            phase_nxt    = idpcb_pkg::PH_SETTLE;
            ph_timer_nxt = settle_len;
            wake_req     = 1'b1;
          end else if (off_timer_r < off_hold_us_r) begin
            off_timer_nxt = off_timer_r + 16'd1;
          end
        end else if (shown != cur_lvl_r) begin
          tgt_lvl_nxt = shown;
          if (step_n != '0) begin
            pulses_nxt   = step_n;
            phase_nxt    = idpcb_pkg::PH_LOW;
            ph_timer_nxt = half_len;
          end else begin
            cur_lvl_nxt = shown;
          end
        end
      end
      idpcb_pkg::PH_SETTLE: begin
        ph_timer_nxt = timer_dec;
        if (timer_dec == 8'd0) begin
          if (step_n != '0) begin
            cur_lvl_nxt  = FULL_LVL;
            pulses_nxt   = step_n;
            phase_nxt    = idpcb_pkg::PH_LOW;
            ph_timer_nxt = half_len;
          end else begin
            cur_lvl_nxt = tgt_lvl_r;
            phase_nxt   = idpcb_pkg::PH_IDLE;
          end
        end
      end
      idpcb_pkg::PH_LOW: begin
        ph_timer_nxt = timer_dec;
        if (timer_dec == 8'd0) begin
          phase_nxt    = idpcb_pkg::PH_HIGH;
          ph_timer_nxt = half_len;
        end
      end
      idpcb_pkg::PH_HIGH: begin
        ph_timer_nxt = timer_dec;
        if (timer_dec == 8'd0) begin
          // one finished pulse steps the chip down, wrapping from 1 to full
          pulses_nxt = (pulses_r != '0) ? pulses_r - PULSE_W'(1) : '0;
          if (pulses_nxt == '0) begin
            cur_lvl_nxt = tgt_lvl_r;
            phase_nxt   = idpcb_pkg::PH_IDLE;
          end else begin
            cur_lvl_nxt  = (cur_lvl_r <= LVL_W'(1)) ? FULL_LVL : cur_lvl_r - LVL_W'(1);
            phase_nxt    = idpcb_pkg::PH_LOW;
            ph_timer_nxt = half_len;
          end
        end
      end
      default: ;
    endcase

    // Pin follows the new phase and level
    if (phase_nxt == idpcb_pkg::PH_IDLE) begin
      pin = (cur_lvl_nxt != '0);
    end else begin
      pin = (phase_nxt != idpcb_pkg::PH_LOW);
    end

    out_data_nxt.pin_level     = pin;
    out_data_nxt.shown_level   = shown;
    out_data_nxt.applied_level = cur_lvl_nxt;
    out_data_nxt.busy_res      = (phase_nxt != idpcb_pkg::PH_IDLE);
    out_data_nxt.panel_sleep   = sleep_req;
    out_data_nxt.panel_wake    = wake_req;
    out_data_nxt.blanked       = (shown == '0) && (wanted_level_r != '0);
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_lvl_r   <= '0;
      tgt_lvl_r   <= '0;
      phase_r     <= idpcb_pkg::PH_IDLE;
      ph_timer_r  <= '0;
      off_timer_r <= '0;
      pulses_r    <= '0;
    end else if (in_fire) begin
      cur_lvl_r   <= cur_lvl_nxt;
      tgt_lvl_r   <= tgt_lvl_nxt;
      phase_r     <= phase_nxt;
      ph_timer_r  <= ph_timer_nxt;
      off_timer_r <= off_timer_nxt;
      pulses_r    <= pulses_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted tick produced no result beat");

  a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.panel_sleep) |->
      (out_data.applied_level == '0 && !out_data.busy_res && !out_data.pin_level))
    else $error("sleep request while light not dark");

  a_idle_pin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.busy_res) |->
      (out_data.pin_level == (out_data.applied_level != '0)))
    else $error("idle pin level disagrees with applied level");

  a_wake_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.panel_wake) |->
      (out_data.busy_res && out_data.pin_level && out_data.applied_level == '0))
    else $error("wake request without settle phase");
`endif

endmodule

// ===== sim/idle_dimming_pulse_count_backlight_test.sv =====
// Self-checking bench for the idle-dimming backlight block: predicts each tick's result beat.
`timescale 1ns / 1ps

module idle_dimming_pulse_count_backlight_test;

  localparam int unsigned LVL_W       = idpcb_pkg::LVL_W;
  localparam int unsigned PULSE_W     = idpcb_pkg::PULSE_W;
  localparam int unsigned LEVEL_STEPS = idpcb_pkg::LEVEL_STEPS;
  localparam int unsigned CFG_IDX_W   = idpcb_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W  = idpcb_pkg::CFG_DATA_W;
  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(LEVEL_STEPS);
  localparam int PHASES = 12;
  localparam int TICKS_PER_PHASE = 170;

  // Mirror of the block: policy, sequencer state and register copy
  class dimmer_scoreboard;
    logic [LVL_W-1:0]   wanted, dim_lvl;
    logic               idle_en;
    logic [31:0]        dim_after, off_after;
    logic [15:0]        off_hold;
    logic [7:0]         settle_us, half_us;
    logic [LVL_W-1:0]   cur_lvl, tgt_lvl;
    logic [1:0]         ph;
    logic [15:0]        ph_timer, off_timer;
    logic [PULSE_W-1:0] pulses_left;
    idpcb_pkg::out_t    dimmer_replies[$];
    int unsigned        failures;

    function new();
      wanted      = 5'd16;
      idle_en     = 1'b1;
      dim_after   = 32'd30000;
      off_after   = 32'd120000;
      dim_lvl     = 5'd4;
      off_hold    = 16'd3000;
      settle_us   = 8'd30;
      half_us     = 8'd1;
      cur_lvl     = '0;
      tgt_lvl     = '0;
      ph          = idpcb_pkg::PH_IDLE;
      ph_timer    = '0;
      off_timer   = '0;
      pulses_left = '0;
      failures    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        idpcb_pkg::REG_WANTED_LEVEL:  wanted    = v[LVL_W-1:0];
        idpcb_pkg::REG_IDLE_ENABLE:   idle_en   = v[0];
        idpcb_pkg::REG_DIM_AFTER_MS:  dim_after = v;
        idpcb_pkg::REG_OFF_AFTER_MS:  off_after = v;
        idpcb_pkg::REG_DIM_LEVEL:     dim_lvl   = v[LVL_W-1:0];
        idpcb_pkg::REG_OFF_HOLD_US:   off_hold  = v[15:0];
        idpcb_pkg::REG_ON_SETTLE_US:  settle_us = v[7:0];
        idpcb_pkg::REG_PULSE_HALF_US: half_us   = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [LVL_W-1:0] cap(logic [LVL_W-1:0] v);
      return (v > FULL_LVL) ? FULL_LVL : v;
    endfunction

    // A zero duration still lasts one tick
    function logic [15:0] nonzero_ticks(logic [7:0] v);
      return (v == 8'd0) ? 16'd1 : {8'd0, v};
    endfunction

    function int unsigned step_count(logic [LVL_W-1:0] from_lvl, logic [LVL_W-1:0] to_lvl);
      if (from_lvl == 0 || to_lvl == 0 || from_lvl > FULL_LVL || to_lvl > FULL_LVL)
        return 0;
      return (LEVEL_STEPS + from_lvl - to_lvl) % LEVEL_STEPS;
    endfunction

    function logic [LVL_W-1:0] policy(idpcb_pkg::in_t t);
      logic [LVL_W-1:0] want, dim;
      want = cap(wanted);
      dim  = cap(dim_lvl);
      if (!idle_en || t.progress_bar)
        return want;
      if (t.idle_ms >= off_after && !t.critical_unread)
        return '0;
      if (t.idle_ms >= dim_after)
        return (dim < want) ? dim : want;
      return want;
    endfunction

    // Start the pulse train, or take the target at once when no steps are needed
    function void begin_steps();
      int unsigned n;
      n = step_count(cur_lvl, tgt_lvl);
      if (n > 0) begin
        pulses_left = PULSE_W'(n);
        ph          = idpcb_pkg::PH_LOW;
        ph_timer    = nonzero_ticks(half_us);
      end else begin
        cur_lvl = tgt_lvl;
        ph      = idpcb_pkg::PH_IDLE;
      end
    endfunction

    // Advance one microsecond tick and queue the beat it should produce
    function void note_tick(idpcb_pkg::in_t t);
      logic [LVL_W-1:0] shown;
      idpcb_pkg::out_t  r;
      shown = policy(t);
      r     = '0;
      if (ph == idpcb_pkg::PH_IDLE) begin
        if (shown != cur_lvl && shown == 0) begin
          cur_lvl       = '0;
          off_timer     = '0;
          r.panel_sleep = 1'b1;
        end else if (cur_lvl == 0) begin
          if (shown != 0 && off_timer >= off_hold) begin
            tgt_lvl      = shown;
            ph           = idpcb_pkg::PH_SETTLE;
            ph_timer     = nonzero_ticks(settle_us);
            r.panel_wake = 1'b1;
          end else if (off_timer < off_hold) begin
            off_timer = off_timer + 16'd1;
          end
        end else if (shown != cur_lvl) begin
          tgt_lvl = shown;
          begin_steps();
        end
      end else begin
        if (ph_timer > 0)
          ph_timer = ph_timer - 16'd1;
        if (ph_timer == 0) begin
          case (ph)
            idpcb_pkg::PH_SETTLE: begin
              cur_lvl = FULL_LVL;
              begin_steps();
            end
            idpcb_pkg::PH_LOW: begin
              ph       = idpcb_pkg::PH_HIGH;
              ph_timer = nonzero_ticks(half_us);
            end
            default: begin
              // One finished pulse: step down, wrapping from 1 to full
              cur_lvl = (cur_lvl <= 1) ? FULL_LVL : cur_lvl - 1'b1;
              if (pulses_left > 0)
                pulses_left = pulses_left - 1'b1;
              if (pulses_left == 0) begin
                cur_lvl = tgt_lvl;
                ph      = idpcb_pkg::PH_IDLE;
              end else begin
                ph       = idpcb_pkg::PH_LOW;
                ph_timer = nonzero_ticks(half_us);
              end
            end
          endcase
        end
      end
      r.pin_level     = (ph == idpcb_pkg::PH_IDLE) ? (cur_lvl != 0)
                                                   : (ph != idpcb_pkg::PH_LOW);
      r.shown_level   = shown;
      r.applied_level = cur_lvl;
      r.busy_res      = (ph != idpcb_pkg::PH_IDLE);
      r.blanked       = (shown == 0 && wanted != 0);
      dimmer_replies.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_beat(idpcb_pkg::out_t got);
      idpcb_pkg::out_t want;
      if (dimmer_replies.size() == 0) begin
        $error("result beat with no tick awaiting it");
        failures++;
        return;
      end
      want = dimmer_replies.pop_front();
      match_field("pin_level", 32'(want.pin_level), 32'(got.pin_level));
      match_field("shown_level", 32'(want.shown_level), 32'(got.shown_level));
      match_field("applied_level", 32'(want.applied_level), 32'(got.applied_level));
      match_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      match_field("panel_sleep", 32'(want.panel_sleep), 32'(got.panel_sleep));
      match_field("panel_wake", 32'(want.panel_wake), 32'(got.panel_wake));
      match_field("blanked", 32'(want.blanked), 32'(got.blanked));
    endfunction

    function int waiting();
      return dimmer_replies.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  idpcb_pkg::in_t        in_data;
  logic                  out_valid;
  logic                  out_ready;
  idpcb_pkg::out_t       out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dimmer_scoreboard sb = new();
  bit               steady;

  idle_dimming_pulse_count_backlight uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop should the block hang
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int draw_pause();
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic idpcb_pkg::in_t tick_of(logic [31:0] idle, logic bar, logic crit);
    idpcb_pkg::in_t t;
    t.idle_ms         = idle;
    t.progress_bar    = bar;
    t.critical_unread = crit;
    return t;
  endfunction

  // Land within a few ms of a threshold, clamped to the field
  function automatic logic [31:0] near(logic [31:0] thr);
    longint v;
    v = longint'(thr) + longint'($urandom_range(0, 8)) - 4;
    if (v < 0)
      v = 0;
    if (v > 64'hFFFF_FFFF)
      v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_idle();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return near(sb.dim_after);
      2:       return near(sb.off_after);
      3:       return $urandom_range(0, 3000);
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  // Offer one tick; valid is left high until the next call or rest_inputs
  task automatic send_tick(input idpcb_pkg::in_t t);
    int gap;
    gap = draw_pause();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_tick(t);
  endtask

  task automatic rest_inputs();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(input logic [31:0] w, input logic en, input logic [31:0] da,
                             input logic [31:0] oa, input logic [31:0] dl,
                             input logic [31:0] oh, input logic [31:0] st,
                             input logic [31:0] hf);
    write_cfg(idpcb_pkg::REG_WANTED_LEVEL, w);
    write_cfg(idpcb_pkg::REG_IDLE_ENABLE, {31'd0, en});
    write_cfg(idpcb_pkg::REG_DIM_AFTER_MS, da);
    write_cfg(idpcb_pkg::REG_OFF_AFTER_MS, oa);
    write_cfg(idpcb_pkg::REG_DIM_LEVEL, dl);
    write_cfg(idpcb_pkg::REG_OFF_HOLD_US, oh);
    write_cfg(idpcb_pkg::REG_ON_SETTLE_US, st);
    write_cfg(idpcb_pkg::REG_PULSE_HALF_US, hf);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Phase settings: all-low, all-high, long settle and pulses, then random mid-range
  task automatic phase_config(input int p);
    case (p)
      0: load_config(0, 1'b0, 0, 0, 0, 0, 0, 0);
      1: load_config(31, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 65535, 255, 255);
      2: load_config(16, 1'b1, $urandom_range(0, 200), $urandom_range(300, 600),
                     $urandom_range(0, 16), 0, 255, 255);
      default: load_config($urandom_range(0, 7) == 0 ? $urandom_range(17, 31)
                                                     : $urandom_range(0, 16),
                           $urandom_range(0, 3) != 0,
                           $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1500),
                           $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3000),
                           $urandom_range(0, 7) == 0 ? $urandom_range(17, 31)
                                                     : $urandom_range(0, 16),
                           $urandom_range(0, 24), $urandom_range(0, 6),
                           $urandom_range(0, 3));
    endcase
  endtask

  // Take every result beat, with a random stall before each one unless the run is steady
  initial begin
    int pause;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      pause = draw_pause();
      @(negedge clk);
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat(out_data);
  end

  initial begin
    int          count;
    int          run_len;
    bit          paused;
    logic [31:0] idle;
    logic        bar;
    logic        crit;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: wake, instant full level, single pulse, blanking, policy overrides,
    // a blank request arriving mid-pulse, threshold edges and zero durations
    load_config(16, 1'b1, 10, 20, 15, 0, 0, 0);
    send_tick(tick_of(32'd0, 1'b0, 1'b0));
    send_tick(tick_of(32'd0, 1'b0, 1'b0));
    send_tick(tick_of(32'd10, 1'b0, 1'b0));
    send_tick(tick_of(32'd10, 1'b0, 1'b0));
    send_tick(tick_of(32'd10, 1'b0, 1'b0));
    send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b1));
    send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_tick(tick_of(32'hFFFF_FFFF, 1'b1, 1'b0));
    send_tick(tick_of(32'd19, 1'b0, 1'b0));
    send_tick(tick_of(32'd20, 1'b1, 1'b1));
    send_tick(tick_of(32'd0, 1'b0, 1'b0));
    send_tick(tick_of(32'd10, 1'b0, 1'b0));
    send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_tick(tick_of(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_tick(tick_of(32'd9, 1'b0, 1'b0));
    send_tick(tick_of(32'd9, 1'b0, 1'b0));
    send_tick(tick_of(32'd20, 1'b0, 1'b1));
    send_tick(tick_of(32'd20, 1'b0, 1'b0));

    // Random phases: runs of steady idle time so the sequencer gets through, plus noise
    for (int p = 0; p < PHASES; p++) begin
      rest_inputs();
      wait_drained();
      phase_config(p);
      steady = ($urandom_range(0, 3) == 0);
      count  = 0;
      paused = 1'b0;
      while (count < TICKS_PER_PHASE) begin
        // Hold off the sender once per phase until the block has emptied
        if (!paused && count >= TICKS_PER_PHASE / 2) begin
          rest_inputs();
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_tick(tick_of($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          count++;
        end else begin
          run_len = $urandom_range(1, 40);
          idle    = pick_idle();
          bar     = ($urandom_range(0, 7) == 0);
          crit    = ($urandom_range(0, 3) == 0);
          for (int k = 0; k < run_len && count < TICKS_PER_PHASE; k++) begin
            if ($urandom_range(0, 15) == 0)
              crit = ~crit;
            send_tick(tick_of(idle, bar, crit));
            count++;
          end
        end
      end
    end

    rest_inputs();
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.waiting() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/idpcb_pkg.sv
src/idle_dimming_pulse_count_backlight.sv
sim/idle_dimming_pulse_count_backlight_test.sv
